/* hdl/dual_stack_shared_buffer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual stack shared buffer
// Concurrent checks that are clocked by clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_BUFFER_MACROS_SVH
`define DUAL_STACK_SHARED_BUFFER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that a property holds at every clock edge outside reset.
`define DSSB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never occurs outside reset.
`define DSSB_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DSSB_ASSERT(lbl, prop, msg)
`define DSSB_NEVER(lbl, cond, msg)
`endif

`endif

/* hdl/dssb_pkg.sv */
// ----------------------------------------------------------------------------
// dssb_pkg
// Sizes, operation and status codes, and the memory request bundle.
// ----------------------------------------------------------------------------
package dssb_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef logic [1:0] func_t;
	localparam func_t FN_PUSH = 2'd0;
	localparam func_t FN_POP  = 2'd1;
	localparam func_t FN_PEEK = 2'd2;
	localparam func_t FN_DUMP = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_OVERFLOW = 2'd1;
	localparam status_t ST_EMPTY    = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// Store index of position pos (0 = bottom) of the low or high stack.
	function automatic logic [ADDR_W-1:0] slot_of(input logic sel,
		input logic [ADDR_W-1:0] pos);
		slot_of = sel ? (ADDR_W'(DEPTH - 1) - pos) : pos;
	endfunction

endpackage

/* hdl/dssb_ram.sv */
// ----------------------------------------------------------------------------
// dssb_ram
// Shared entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dssb_ram import dssb_pkg::*; (
	input  logic              clk,
	input  ram_req_t          req,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Read data holds until the next read, so a stalled consumer loses nothing.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/dual_stack_shared_buffer.sv */
// Results: push and pop answer in the cycle after the transaction; peek and the first
//   entry of a dump pass through the store's read register and then the output
//   register; later dump entries follow 1 per cycle while the output is not stalled.
// Requests: push and pop 1 transaction per cycle while the output is not stalled; no
//   new request is taken while a peek or dump still reads through the store's single read port.
// Reset: both stack counts clear at once; the entry store is not cleared.
// ----------------------------------------------------------------------------
// dual_stack_shared_buffer
// Two stacks in one memory: the low stack grows up from entry 0, the high
// stack grows down from the top entry. Push, pop, peek and dump requests.
// ----------------------------------------------------------------------------
`include "dual_stack_shared_buffer_macros.svh"

module dual_stack_shared_buffer import dssb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] push_value
	input  logic [7:0]  s_tuser,   // [1:0] func, [2] which_stack, [7:3] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] read_value
	output logic [7:0]  m_tuser,   // [1:0] status, [7:2] zero
	output logic        m_tlast    // last result of the request
);

	typedef enum logic {S_IDLE, S_READ} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  low_cnt_q;
	logic [CNT_W-1:0]  high_cnt_q;
	logic [ADDR_W-1:0] pos_q;      // stack position of the entry in flight
	logic              sel_q;
	logic              dump_q;

	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_data_q;
	status_t           m_status_q;
	logic              m_last_q;

	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rdata;

	func_t             in_func;
	logic              in_sel;
	logic [CNT_W-1:0]  sel_cnt;
	logic [CNT_W:0]    cnt_sum;
	logic              sel_empty;
	logic              full;
	logic              s_acc;
	logic              out_free;
	logic              out_load_rd;
	logic              dump_more;

	assign in_func   = s_tuser[1:0];
	assign in_sel    = s_tuser[2];
	assign sel_cnt   = in_sel ? high_cnt_q : low_cnt_q;
	assign cnt_sum   = {1'b0, low_cnt_q} + {1'b0, high_cnt_q};
	assign sel_empty = (sel_cnt == '0);
	assign full      = (cnt_sum >= (CNT_W + 1)'(DEPTH));

	// The output register is free when empty or when its transaction completes now.
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign s_acc    = s_tvalid && s_tready;

	// In the read state, move the fetched entry to the output once it is free.
	assign out_load_rd = (state_q == S_READ) && out_free;
	assign dump_more   = dump_q && (pos_q != '0);

	// Memory requests: push writes at acceptance; peek and dump fetch the top
	// entry at acceptance; a running dump fetches the next entry below while
	// the current one moves to the output. Only one request is in work, so a
	// write and a read of the same entry never overlap.
	always_comb begin
		ram_req = '0;
		if (s_acc && (in_func == FN_PUSH) && !full) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = slot_of(in_sel, sel_cnt[ADDR_W-1:0]);
			ram_req.wdata = s_tdata[DATA_W-1:0];
		end
		if (s_acc && ((in_func == FN_PEEK) || (in_func == FN_DUMP)) && !sel_empty) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = slot_of(in_sel, ADDR_W'(sel_cnt - CNT_W'(1)));
		end else if (out_load_rd && dump_more) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = slot_of(sel_q, pos_q - ADDR_W'(1));
		end
	end

	dssb_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Sequencer, stack counts and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			low_cnt_q  <= '0;
			high_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						unique case (in_func)
							FN_PUSH: begin
								// Answer now; advance the count unless the stacks meet.
								m_tvalid_q <= 1'b1;
								m_data_q   <= '0;
								m_last_q   <= 1'b1;
								m_status_q <= full ? ST_OVERFLOW : ST_OK;
								if (!full) begin
									if (in_sel) begin
										high_cnt_q <= high_cnt_q + CNT_W'(1);
									end else begin
										low_cnt_q <= low_cnt_q + CNT_W'(1);
									end
								end
							end
							FN_POP: begin
								m_tvalid_q <= 1'b1;
								m_data_q   <= '0;
								m_last_q   <= 1'b1;
								m_status_q <= sel_empty ? ST_EMPTY : ST_OK;
								if (!sel_empty) begin
									if (in_sel) begin
										high_cnt_q <= high_cnt_q - CNT_W'(1);
									end else begin
										low_cnt_q <= low_cnt_q - CNT_W'(1);
									end
								end
							end
							default: begin
								// Peek or dump: empty answers at once, else wait for the read.
								if (sel_empty) begin
									m_tvalid_q <= 1'b1;
									m_data_q   <= '0;
									m_last_q   <= 1'b1;
									m_status_q <= ST_EMPTY;
								end else begin
									// Drop the previous result; it completes or was never there.
									m_tvalid_q <= 1'b0;
									state_q    <= S_READ;
									pos_q      <= ADDR_W'(sel_cnt - CNT_W'(1));
									sel_q      <= in_sel;
									dump_q     <= (in_func == FN_DUMP);
								end
							end
						endcase
					end else if (m_tvalid_q && m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				S_READ: begin
					// Without a load the output register is full and stalled: hold it.
					if (out_load_rd) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= ram_rdata;
						m_status_q <= ST_OK;
						m_last_q   <= !dump_more;
						if (dump_more) begin
							pos_q <= pos_q - ADDR_W'(1);
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = {6'd0, m_status_q};
	assign m_tlast  = m_last_q;

	// The two stacks together never hold more than the store.
	`DSSB_NEVER(a_cnt_bound, cnt_sum > (CNT_W + 1)'(DEPTH), "stack counts exceed store depth")
	// A read from the store is always followed by the read state that consumes it.
	`DSSB_ASSERT(a_read_used, ram_req.re |=> (state_q == S_READ), "read data not consumed")
	// Counts move only as a result of an accepted request.
	`DSSB_ASSERT(a_cnt_cause, !$stable(low_cnt_q) || !$stable(high_cnt_q) |-> $past(s_acc),
		"stack count changed without a request")
	// Overflow and empty results always end their request.
	`DSSB_ASSERT(a_err_last, m_tvalid_q && (m_status_q != ST_OK) |-> m_last_q,
		"error result not marked last")

endmodule
